@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the SIEVE cache RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/scr_pkg.sv @@
// Package for the SIEVE cache: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package scr_pkg;
    localparam int SLOTS      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int SLOT_W     = $clog2(SLOTS + 1);
    localparam int QDEPTH     = 2;
    localparam int QIDX_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam logic [SLOT_W-1:0] NIL = SLOT_W'(SLOTS);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        FUNC_GET    = 2'd0,
        FUNC_PUT    = 2'd1,
        FUNC_GETPUT = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_GET,
        OP_PUT,
        OP_GETPUT
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_INSERT,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

@@ rtl/core/scr_if.sv @@
// Channel interfaces of the SIEVE cache: request, response, configuration.
// Depends on scr_pkg.
`default_nettype none
interface scr_req_if import scr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] new_value;
    modport source (output valid, func, key, new_value, input ready);
    modport sink (input valid, func, key, new_value, output ready);
endinterface

interface scr_rsp_if import scr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] got_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
    modport source (output valid, hit, got_value, evicted, evicted_key, input ready);
    modport sink (input valid, hit, got_value, evicted, evicted_key, output ready);
endinterface

interface scr_cfg_if import scr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/scr_front.sv @@
// Front end: accepts request items and decodes them into queue entries.
// Depends on scr_pkg and scr_if.
`default_nettype none
module scr_front
    import scr_pkg::*;
(
    scr_req_if.sink    req,
    input  queue_stat_t qstat,
    output logic       push,
    output item_t      push_item
);
    op_t op;

    always_comb
    begin
        unique case (func_t'(req.func))
            FUNC_GET:    op = OP_GET;
            FUNC_PUT:    op = OP_PUT;
            FUNC_GETPUT: op = OP_GETPUT;
            default:     op = OP_NOP;
        endcase
    end

    assign req.ready       = !qstat.full;
    assign push            = req.valid && !qstat.full;
    assign push_item.op    = op;
    assign push_item.key   = req.key;
    assign push_item.value = req.new_value;
endmodule
`default_nettype wire

@@ rtl/core/scr_queue.sv @@
// Short item queue between the front end and the back end.
// Depends on scr_pkg.
`default_nettype none
module scr_queue
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       push_item,
    input  logic        pop,
    output item_t       head,
    output queue_stat_t qstat
);
    item_t               mem [QDEPTH];
    logic [QIDX_W-1:0]   wr_reg;
    logic [QIDX_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == QIDX_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == QIDX_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/scr_back.sv @@
// Back end: tag lookup, SIEVE hand walk, insertion and the response register.
// Depends on scr_pkg, scr_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module scr_back
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       head,
    input  queue_stat_t qstat,
    output logic        pop,
    scr_rsp_if.source   rsp,
    scr_cfg_if.sink     cfg
);
    logic                  valid_reg   [SLOTS];
    logic                  visited_reg [SLOTS];
    logic [KEY_BITS-1:0]   key_reg     [SLOTS];
    logic [VALUE_BITS-1:0] data_reg    [SLOTS];
    logic [SLOT_W-1:0]     newer_reg   [SLOTS];
    logic [SLOT_W-1:0]     older_reg   [SLOTS];
    logic [SLOT_W-1:0]     oldest_reg;
    logic [SLOT_W-1:0]     newest_reg;
    logic [SLOT_W-1:0]     hand_reg;
    logic [SLOT_W-1:0]     cur_reg;
    logic [SLOT_W-1:0]     count_reg;
    logic [CAP_W-1:0]      cap_reg;
    state_t                state_reg;
    state_t                state_next;
    item_t                 item_reg;
    logic                  pend_hit_reg;
    logic [VALUE_BITS-1:0] pend_got_reg;
    logic                  pend_ev_reg;
    logic [KEY_BITS-1:0]   pend_evkey_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_hit_reg;
    logic [VALUE_BITS-1:0] rsp_got_reg;
    logic                  rsp_ev_reg;
    logic [KEY_BITS-1:0]   rsp_evkey_reg;

    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic              lookup_hit;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    logic [SLOT_W-1:0] cap_eff;
    logic              need_evict;
    logic              hand_ok;
    logic [IDX_W-1:0]  cur_idx;
    logic [IDX_W-1:0]  hand_idx;
    logic              emit_load;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == item_reg.key)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = SLOT_W'(1);
        end
        else if (SLOT_W'(cap_reg) > NIL)
        begin
            cap_eff = NIL;
        end
        else
        begin
            cap_eff = SLOT_W'(cap_reg);
        end
    end

    assign lookup_hit = hit_any && (item_reg.op != OP_NOP);
    assign need_evict = (count_reg >= cap_eff) || !free_any;
    assign hand_idx   = hand_reg[IDX_W-1:0];
    assign hand_ok    = (hand_reg < NIL) && valid_reg[hand_idx];
    assign cur_idx    = cur_reg[IDX_W-1:0];
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (item_reg.op == OP_NOP || hit_any || item_reg.op == OP_GET)
                begin
                    state_next = ST_EMIT;
                end
                else if (need_evict)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_WALK:
            begin
                if (cur_reg >= NIL || !visited_reg[cur_idx])
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop = !qstat.empty;
            ST_EMIT: emit_load = !rsp_valid_reg || rsp.ready;
            default:
            begin
                pop       = 1'b0;
                emit_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        if (emit_load)
        begin
            rsp_hit_reg   <= pend_hit_reg;
            rsp_got_reg   <= pend_got_reg;
            rsp_ev_reg    <= pend_ev_reg;
            rsp_evkey_reg <= pend_evkey_reg;
        end
        if (state_reg == ST_LOOKUP && lookup_hit)
        begin
            pend_got_reg <= data_reg[hit_idx];
            if (item_reg.op == OP_PUT)
            begin
                data_reg[hit_idx] <= item_reg.value;
            end
        end
        if (pop)
        begin
            pend_got_reg   <= '0;
            pend_evkey_reg <= '0;
        end
        if (state_reg == ST_WALK && cur_reg < NIL && !visited_reg[cur_idx])
        begin
            pend_evkey_reg <= key_reg[cur_idx];
        end
        if (state_reg == ST_LOOKUP)
        begin
            cur_reg <= hand_ok ? hand_reg : oldest_reg;
        end
        if (state_reg == ST_WALK && cur_reg < NIL && visited_reg[cur_idx])
        begin
            cur_reg <= (newer_reg[cur_idx] < NIL) ? newer_reg[cur_idx] : oldest_reg;
        end
        if (state_reg == ST_INSERT && free_any)
        begin
            key_reg[free_idx]   <= item_reg.key;
            data_reg[free_idx]  <= item_reg.value;
            newer_reg[free_idx] <= NIL;
            older_reg[free_idx] <= newest_reg;
            if (newest_reg < NIL)
            begin
                newer_reg[newest_reg[IDX_W-1:0]] <= SLOT_W'(free_idx);
            end
        end
        if (state_reg == ST_WALK && cur_reg < NIL && !visited_reg[cur_idx])
        begin
            if (older_reg[cur_idx] < NIL)
            begin
                newer_reg[older_reg[cur_idx][IDX_W-1:0]] <= newer_reg[cur_idx];
            end
            if (newer_reg[cur_idx] < NIL)
            begin
                older_reg[newer_reg[cur_idx][IDX_W-1:0]] <= older_reg[cur_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i]   <= 1'b0;
                visited_reg[i] <= 1'b0;
            end
            oldest_reg    <= NIL;
            newest_reg    <= NIL;
            hand_reg      <= NIL;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            state_reg     <= ST_IDLE;
            pend_hit_reg  <= 1'b0;
            pend_ev_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (emit_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                pend_hit_reg <= 1'b0;
                pend_ev_reg  <= 1'b0;
            end
            if (state_reg == ST_LOOKUP && lookup_hit)
            begin
                pend_hit_reg         <= 1'b1;
                visited_reg[hit_idx] <= 1'b1;
            end
            if (state_reg == ST_WALK && cur_reg < NIL)
            begin
                visited_reg[cur_idx] <= 1'b0;
                if (!visited_reg[cur_idx])
                begin
                    if (older_reg[cur_idx] >= NIL)
                    begin
                        oldest_reg <= newer_reg[cur_idx];
                    end
                    if (newer_reg[cur_idx] >= NIL)
                    begin
                        newest_reg <= older_reg[cur_idx];
                    end
                    hand_reg           <= newer_reg[cur_idx];
                    valid_reg[cur_idx] <= 1'b0;
                    count_reg          <= count_reg - 1'b1;
                    pend_ev_reg        <= 1'b1;
                end
            end
            if (state_reg == ST_INSERT && free_any)
            begin
                valid_reg[free_idx]   <= 1'b1;
                visited_reg[free_idx] <= 1'b0;
                if (newest_reg >= NIL)
                begin
                    oldest_reg <= SLOT_W'(free_idx);
                end
                newest_reg <= SLOT_W'(free_idx);
                if (count_reg == '0)
                begin
                    hand_reg <= SLOT_W'(free_idx);
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.got_value   = rsp_got_reg;
    assign rsp.evicted     = rsp_ev_reg;
    assign rsp.evicted_key = rsp_evkey_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= NIL)
    `ASSERT_IMPLIES(a_walk_nonempty, state_reg == ST_WALK, count_reg != '0)
    `ASSERT_IMPLIES(a_insert_has_free, state_reg == ST_INSERT, free_any)
endmodule
`default_nettype wire

@@ rtl/core/sieve_cache_replacement.sv @@
// A request passes the queue, then IDLE, LOOKUP and EMIT into the response register for a
// hit, a get miss or an unused code; an insert without eviction adds INSERT and an eviction
// adds WALK, where the hand clears visited entries. EMIT waits for an unaccepted response.
// The back end takes one item at a time; requests enter a two-entry queue until it is full.
// Reset (rst_n, asynchronous, active low) empties the cache and sets capacity to 16.
`default_nettype none
module sieve_cache_replacement
    import scr_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    scr_req_if.sink   req,
    scr_rsp_if.source rsp,
    scr_cfg_if.sink   cfg
);
    queue_stat_t qstat;
    logic        push;
    item_t       push_item;
    logic        pop;
    item_t       head;

    scr_front u_front (
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    scr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    scr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .rsp   (rsp),
        .cfg   (cfg)
    );
endmodule
`default_nettype wire
